// ----- src/assert_macros.svh -----
// assertion macros used by the slot table datapath
// expects clk and arst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// consequent holds in the cycle of the antecedent
`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ----- src/gst_pkg.sv -----
// types and constants of the generational slot table
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package gst_pkg;

	localparam int KIND_W      = 3;
	localparam int KEY_W       = 32;
	localparam int HANDLE_W    = 32;
	localparam int ID_W        = 16;
	localparam int VER_W       = 16;
	localparam int COUNT_W     = 6;
	localparam int MAX_RESULTS = 32;
	localparam int FREED_W     = $clog2(MAX_RESULTS + 1);

	typedef enum logic [KIND_W-1:0] {
		KIND_ALLOC       = 3'd0,
		KIND_RELEASE     = 3'd1,
		KIND_LOOKUP_H    = 3'd2,
		KIND_LOOKUP_K    = 3'd3,
		KIND_RELEASE_ALL = 3'd4
	} kind_t;

	typedef struct packed {
		logic load;
		logic rd;
		logic exec;
	} gst_cmd_t;

	typedef struct packed {
		logic emit;
		logic done;
		logic out_free;
	} gst_sts_t;

endpackage

`default_nettype wire

// ----- src/gst_ctrl.sv -----
// controller of the slot table: sequences request load, slot read and execute
// depends on gst_pkg
`timescale 1ns / 1ps
`default_nettype none

module gst_ctrl import gst_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire gst_sts_t sts,
	output gst_cmd_t      cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_EXEC
	} state_t;

	state_t state_q;
	logic   in_ready_q;
	logic   fire;

	always_comb begin
		fire     = (state_q == ST_EXEC) && (sts.out_free || !sts.emit);
		cmd.load = in_valid && in_ready_q;
		cmd.rd   = (state_q == ST_READ);
		cmd.exec = fire;
	end

	assign in_ready = in_ready_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			in_ready_q <= 1'b1;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid && in_ready_q) begin
						state_q    <= ST_READ;
						in_ready_q <= 1'b0;
					end
				end
				ST_READ: begin
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (fire) begin
						if (sts.done) begin
							state_q    <= ST_IDLE;
							in_ready_q <= 1'b1;
						end else begin
							state_q <= ST_READ;
						end
					end
				end
				default: begin
					state_q    <= ST_IDLE;
					in_ready_q <= 1'b1;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- src/gst_dp.sv -----
// datapath of the slot table: use bits, version and key memories, count, result register
// depends on gst_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module gst_dp import gst_pkg::*; #(
	parameter int SLOT_COUNT = 32
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic [KIND_W-1:0]   kind,
	input  wire logic [KEY_W-1:0]    key,
	input  wire logic [HANDLE_W-1:0] handle,
	input  wire gst_cmd_t            cmd,
	output gst_sts_t                 sts,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic                     status,
	output logic [HANDLE_W-1:0]      handle_out,
	output logic [KEY_W-1:0]         key_out,
	output logic [COUNT_W-1:0]       used_count,
	output logic                     last
);

	localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	kind_t                 kind_q;
	logic [KEY_W-1:0]      key_q;
	logic [HANDLE_W-1:0]   handle_q;

	logic [SLOT_COUNT-1:0] in_use_q;
	logic [SLOT_COUNT-1:0] ver_vld_q;
	logic [VER_W-1:0]      ver_mem [SLOT_COUNT];
	logic [KEY_W-1:0]      key_mem [SLOT_COUNT];

	logic [IDX_W-1:0]      addr_q;
	logic [VER_W-1:0]      ver_rd_q;
	logic [KEY_W-1:0]      key_rd_q;
	logic                  vvld_q;
	logic [IDX_W-1:0]      scan_q;
	logic [FREED_W-1:0]    freed_q;
	logic [COUNT_W-1:0]    count_q;
	logic                  out_valid_q;

	logic [IDX_W-1:0]      free_idx;
	logic [IDX_W-1:0]      used_idx;
	logic [IDX_W-1:0]      addr_sel;
	logic [VER_W-1:0]      ver_cur;
	logic [VER_W-1:0]      ver_inc;
	logic [VER_W-1:0]      ver_new;
	logic                  id_ok;
	logic                  hit;
	logic                  key_hit;
	logic                  full;
	logic                  any_used;
	logic                  only_one;
	logic                  at_end;
	logic [HANDLE_W-1:0]   handle_cur;

	logic                  emit;
	logic                  done;
	logic                  ok;
	logic [HANDLE_W-1:0]   res_h;
	logic [KEY_W-1:0]      res_k;
	logic                  res_last;
	logic                  set_use;
	logic                  clr_use;
	logic                  scan_adv;
	logic [COUNT_W-1:0]    count_nx;

	// lowest free and lowest used slot
	always_comb begin
		free_idx = '0;
		used_idx = '0;
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (!in_use_q[i]) free_idx = IDX_W'(i);
			if (in_use_q[i])  used_idx = IDX_W'(i);
		end
	end

	always_comb begin
		case (kind_q)
			KIND_ALLOC:    addr_sel = free_idx;
			KIND_RELEASE:  addr_sel = handle_q[IDX_W-1:0];
			KIND_LOOKUP_H: addr_sel = handle_q[IDX_W-1:0];
			KIND_LOOKUP_K: addr_sel = scan_q;
			default:       addr_sel = used_idx;
		endcase
	end

	always_comb begin
		ver_cur    = vvld_q ? ver_rd_q : '0;
		ver_inc    = ver_cur + VER_W'(1);
		ver_new    = (ver_inc == '0) ? VER_W'(1) : ver_inc;
		id_ok      = handle_q[ID_W-1:0] < ID_W'(SLOT_COUNT);
		hit        = id_ok && in_use_q[addr_q] && (ver_cur == handle_q[HANDLE_W-1:ID_W]);
		key_hit    = in_use_q[addr_q] && (key_rd_q == key_q);
		full       = &in_use_q;
		any_used   = |in_use_q;
		only_one   = (in_use_q & (in_use_q - SLOT_COUNT'(1))) == '0;
		at_end     = (scan_q == IDX_W'(SLOT_COUNT - 1));
		handle_cur = {ver_cur, ID_W'(addr_q)};
	end

	// action for the slot read in the previous step
	always_comb begin
		emit     = 1'b1;
		done     = 1'b1;
		ok       = 1'b0;
		res_h    = '0;
		res_k    = '0;
		res_last = 1'b1;
		set_use  = 1'b0;
		clr_use  = 1'b0;
		scan_adv = 1'b0;
		case (kind_q)
			KIND_ALLOC: begin
				if (!full) begin
					ok      = 1'b1;
					set_use = 1'b1;
					res_h   = {ver_new, ID_W'(addr_q)};
					res_k   = key_q;
				end
			end
			KIND_RELEASE: begin
				if (hit) begin
					ok      = 1'b1;
					clr_use = 1'b1;
					res_h   = handle_cur;
					res_k   = key_rd_q;
				end
			end
			KIND_LOOKUP_H: begin
				if (hit) begin
					ok    = 1'b1;
					res_h = handle_cur;
					res_k = key_rd_q;
				end
			end
			KIND_LOOKUP_K: begin
				if (key_hit) begin
					ok    = 1'b1;
					res_h = handle_cur;
					res_k = key_q;
				end else if (!at_end) begin
					emit     = 1'b0;
					done     = 1'b0;
					scan_adv = 1'b1;
				end
			end
			KIND_RELEASE_ALL: begin
				if (any_used) begin
					ok       = 1'b1;
					clr_use  = 1'b1;
					res_h    = handle_cur;
					res_k    = key_rd_q;
					res_last = only_one || (freed_q == FREED_W'(MAX_RESULTS - 1));
					done     = res_last;
				end else begin
					emit = 1'b0;
				end
			end
			default: begin
				ok = 1'b0;
			end
		endcase
		if (set_use)      count_nx = count_q + COUNT_W'(1);
		else if (clr_use) count_nx = count_q - COUNT_W'(1);
		else              count_nx = count_q;
	end

	always_comb begin
		sts.emit     = emit;
		sts.done     = done;
		sts.out_free = !out_valid_q || out_ready;
	end

	// request and slot read registers, version and key memory writes
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q   <= kind_t'(kind);
			key_q    <= key;
			handle_q <= handle;
		end
		if (cmd.rd) begin
			addr_q   <= addr_sel;
			ver_rd_q <= ver_mem[addr_sel];
			key_rd_q <= key_mem[addr_sel];
			vvld_q   <= ver_vld_q[addr_sel];
		end
		if (cmd.exec && set_use) begin
			ver_mem[addr_q] <= ver_new;
			key_mem[addr_q] <= key_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q  <= '0;
			ver_vld_q <= '0;
			count_q   <= '0;
			scan_q    <= '0;
			freed_q   <= '0;
		end else begin
			if (cmd.load) begin
				scan_q  <= '0;
				freed_q <= '0;
			end
			if (cmd.exec) begin
				if (set_use) begin
					in_use_q[addr_q]  <= 1'b1;
					ver_vld_q[addr_q] <= 1'b1;
				end
				if (clr_use) begin
					in_use_q[addr_q] <= 1'b0;
				end
				if (clr_use && (kind_q == KIND_RELEASE_ALL)) begin
					freed_q <= freed_q + FREED_W'(1);
				end
				if (scan_adv) begin
					scan_q <= scan_q + IDX_W'(1);
				end
				count_q <= count_nx;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.exec && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && emit) begin
			status     <= !ok;
			handle_out <= res_h;
			key_out    <= res_k;
			used_count <= count_nx;
			last       <= res_last;
		end
	end

	assign out_valid = out_valid_q;

	`ASSERT_ALWAYS(a_count_matches_use, count_q == COUNT_W'($countones(in_use_q)), "used count out of step with use bits")
	`ASSERT_IMPLIES(a_no_result_overwrite, cmd.exec && emit, !out_valid_q || out_ready, "result overwritten before taken")
	`ASSERT_ALWAYS(a_freed_capped, freed_q <= FREED_W'(MAX_RESULTS), "release all freed too many slots")

endmodule

`default_nettype wire

// ----- src/generational_slot_table.sv -----
// channel | handshake          | payload
// in      | in_valid/in_ready  | kind, key, handle
// out     | out_valid/out_ready| status, handle_out, key_out, used_count, last
//
// allocate, release and handle lookup go through accept, slot read and execute
// key lookup checks slots from 0 up, one per read and execute step, until a hit
// release all frees one slot per read and execute step, lowest used slot first
// reset clears all use bits and the count at once; no clearing pass
// a waiting result holds the execute step until out_ready takes it
// top level: controller and datapath; depends on gst_pkg, gst_ctrl and gst_dp
`timescale 1ns / 1ps
`default_nettype none

module generational_slot_table import gst_pkg::*; #(
	parameter int SLOT_COUNT = 32
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [KIND_W-1:0]   kind,
	input  wire logic [KEY_W-1:0]    key,
	input  wire logic [HANDLE_W-1:0] handle,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic                     status,
	output logic [HANDLE_W-1:0]      handle_out,
	output logic [KEY_W-1:0]         key_out,
	output logic [COUNT_W-1:0]       used_count,
	output logic                     last
);

	gst_cmd_t cmd;
	gst_sts_t sts;

	gst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	gst_dp #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.kind       (kind),
		.key        (key),
		.handle     (handle),
		.cmd        (cmd),
		.sts        (sts),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.handle_out (handle_out),
		.key_out    (key_out),
		.used_count (used_count),
		.last       (last)
	);

endmodule

`default_nettype wire

// ----- tb/gst_checker.sv -----
// slot table checker: watches both channels, predicts every result and compares
// keeps its own copy of the slot table; depends on gst_pkg
`timescale 1ns / 1ps

module gst_checker import gst_pkg::*; #(
	parameter int SLOT_COUNT = 32
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire logic                in_ready,
	input  wire logic [KIND_W-1:0]   kind,
	input  wire logic [KEY_W-1:0]    key,
	input  wire logic [HANDLE_W-1:0] handle,
	input  wire logic                out_valid,
	input  wire logic                out_ready,
	input  wire logic                status,
	input  wire logic [HANDLE_W-1:0] handle_out,
	input  wire logic [KEY_W-1:0]    key_out,
	input  wire logic [COUNT_W-1:0]  used_count,
	input  wire logic                last,
	output int                       fail_count,
	output int                       pending,
	output logic [SLOT_COUNT-1:0]    used_map,
	output logic [HANDLE_W-1:0]      live_handle [SLOT_COUNT]
);

	typedef struct packed {
		logic                status;
		logic [HANDLE_W-1:0] handle;
		logic [KEY_W-1:0]    key;
		logic [COUNT_W-1:0]  count;
		logic                last;
	} slot_result_t;

	slot_result_t        awaited_results[$];
	slot_result_t        want;
	logic                in_use     [SLOT_COUNT];
	logic [VER_W-1:0]    version    [SLOT_COUNT];
	logic [KEY_W-1:0]    stored_key [SLOT_COUNT];
	logic [COUNT_W-1:0]  live_count;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] exp_val);
		if (fail_count < 50)
			$display("gst_checker: %s got %0h want %0h at %0t", what, got, exp_val, $realtime);
		fail_count++;
	endtask

	function automatic logic [HANDLE_W-1:0] handle_of(input int s);
		return {version[s], ID_W'(s)};
	endfunction

	// slot of a current handle, or -1
	function automatic int match_handle(input logic [HANDLE_W-1:0] h);
		int id;
		id = int'(h[ID_W-1:0]);
		if (id >= SLOT_COUNT)
			return -1;
		if (!in_use[id])
			return -1;
		if (version[id] != h[HANDLE_W-1 -: VER_W])
			return -1;
		return id;
	endfunction

	task automatic await_result(input logic st, input logic [HANDLE_W-1:0] h,
			input logic [KEY_W-1:0] k, input logic lst);
		awaited_results.push_back('{st, h, k, live_count, lst});
	endtask

	task automatic free_slot(input int s, input logic lst);
		logic [KEY_W-1:0] old;
		old = stored_key[s];
		in_use[s] = 1'b0;
		stored_key[s] = '0;
		live_count = live_count - 1'b1;
		await_result(1'b0, handle_of(s), old, lst);
	endtask

	task automatic predict_table_op(input logic [KIND_W-1:0] op,
			input logic [KEY_W-1:0] op_key, input logic [HANDLE_W-1:0] op_handle);
		int s;
		int n;
		int total;
		s = -1;
		n = 0;
		total = 0;
		case (op)
			KIND_ALLOC: begin
				for (int i = 0; i < SLOT_COUNT; i++)
					if (!in_use[i]) begin
						s = i;
						break;
					end
				if (s < 0) begin
					await_result(1'b1, '0, '0, 1'b1);
				end else begin
					version[s] = version[s] + 1'b1;
					if (version[s] == '0)
						version[s] = VER_W'(1);
					in_use[s] = 1'b1;
					stored_key[s] = op_key;
					live_count = live_count + 1'b1;
					await_result(1'b0, handle_of(s), op_key, 1'b1);
				end
			end
			KIND_RELEASE: begin
				s = match_handle(op_handle);
				if (s < 0)
					await_result(1'b1, '0, '0, 1'b1);
				else
					free_slot(s, 1'b1);
			end
			KIND_LOOKUP_H: begin
				s = match_handle(op_handle);
				if (s < 0)
					await_result(1'b1, '0, '0, 1'b1);
				else
					await_result(1'b0, handle_of(s), stored_key[s], 1'b1);
			end
			KIND_LOOKUP_K: begin
				for (int i = 0; i < SLOT_COUNT; i++)
					if (in_use[i] && stored_key[i] == op_key) begin
						s = i;
						break;
					end
				if (s < 0)
					await_result(1'b1, '0, '0, 1'b1);
				else
					await_result(1'b0, handle_of(s), op_key, 1'b1);
			end
			KIND_RELEASE_ALL: begin
				for (int i = 0; i < SLOT_COUNT; i++)
					if (in_use[i])
						total++;
				if (total > MAX_RESULTS)
					total = MAX_RESULTS;
				for (int i = 0; i < SLOT_COUNT; i++)
					if (in_use[i] && n < total) begin
						n++;
						free_slot(i, n == total);
					end
			end
			default: begin
				await_result(1'b1, '0, '0, 1'b1);
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				in_use[i] = 1'b0;
				version[i] = '0;
				stored_key[i] = '0;
			end
			live_count = '0;
			awaited_results.delete();
			pending <= 0;
			used_map <= '0;
			for (int i = 0; i < SLOT_COUNT; i++)
				live_handle[i] <= '0;
		end else begin
			if (in_valid && in_ready)
				predict_table_op(kind, key, handle);
			if (out_valid && out_ready) begin
				if (awaited_results.size() == 0) begin
					report_mismatch("result with none awaited, handle_out", handle_out, '0);
				end else begin
					want = awaited_results.pop_front();
					if (status !== want.status)
						report_mismatch("status", 32'(status), 32'(want.status));
					if (handle_out !== want.handle)
						report_mismatch("handle_out", handle_out, want.handle);
					if (key_out !== want.key)
						report_mismatch("key_out", key_out, want.key);
					if (used_count !== want.count)
						report_mismatch("used_count", 32'(used_count), 32'(want.count));
					if (last !== want.last)
						report_mismatch("last", 32'(last), 32'(want.last));
				end
			end
			pending <= awaited_results.size();
			for (int i = 0; i < SLOT_COUNT; i++) begin
				used_map[i] <= in_use[i];
				live_handle[i] <= handle_of(i);
			end
		end
	end

endmodule

// ----- tb/tb.sv -----
// testbench top for generational_slot_table: clock, reset, item stimulus, verdict
// depends on gst_pkg, gst_checker and the block itself
`timescale 1ns / 1ps

module tb;
	import gst_pkg::*;

	localparam int SLOT_COUNT  = 32;
	localparam int KIND_BAD_LO = int'(KIND_RELEASE_ALL) + 1;
	localparam int KIND_BAD_HI = (1 << KIND_W) - 1;
	localparam int CHOKE_CYCLES = 300;

	logic                clk;
	logic                arst_n   = 1'b0;
	logic                in_valid = 1'b0;
	logic [KIND_W-1:0]   kind     = '0;
	logic [KEY_W-1:0]    key      = '0;
	logic [HANDLE_W-1:0] handle   = '0;
	logic                out_ready = 1'b0;
	logic                choke_rx = 1'b0;

	wire logic                in_ready;
	wire logic                out_valid;
	wire logic                status;
	wire logic [HANDLE_W-1:0] handle_out;
	wire logic [KEY_W-1:0]    key_out;
	wire logic [COUNT_W-1:0]  used_count;
	wire logic                last;

	int                  fail_count;
	int                  pending;
	logic [SLOT_COUNT-1:0] used_map;
	logic [HANDLE_W-1:0] live_handle [SLOT_COUNT];

	logic [KEY_W-1:0]    key_pool [8];
	int                  burst_left;

	generational_slot_table #(.SLOT_COUNT(SLOT_COUNT)) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.key       (key),
		.handle    (handle),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.handle_out(handle_out),
		.key_out   (key_out),
		.used_count(used_count),
		.last      (last)
	);

	gst_checker #(.SLOT_COUNT(SLOT_COUNT)) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.kind       (kind),
		.key        (key),
		.handle     (handle),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.handle_out (handle_out),
		.key_out    (key_out),
		.used_count (used_count),
		.last       (last),
		.fail_count (fail_count),
		.pending    (pending),
		.used_map   (used_map),
		.live_handle(live_handle)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(60_000_000);
		$display("tb: failure");
		$finish;
	end

	// receiver: a randomly chosen stall pattern for each stretch, one long hold on request
	initial begin
		int mode;
		int left;
		bit choke_done;
		mode = 0;
		left = 0;
		choke_done = 1'b0;
		forever begin
			@(posedge clk);
			if (choke_rx && !choke_done) begin
				choke_done = 1'b1;
				out_ready <= 1'b0;
				repeat (CHOKE_CYCLES) @(posedge clk);
			end
			if (left == 0) begin
				mode = $urandom_range(0, 3);
				left = $urandom_range(20, 80);
			end
			left--;
			case (mode)
				0: out_ready <= 1'b1;
				1: out_ready <= 1'($urandom_range(0, 1));
				2: out_ready <= ($urandom_range(0, 4) == 0);
				default: out_ready <= ~out_ready;
			endcase
		end
	end

	// sender: bursts of items with random gaps between them
	task automatic push_item(input logic [KIND_W-1:0] k, input logic [KEY_W-1:0] ky,
			input logic [HANDLE_W-1:0] h);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 4);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		if (burst_left > 0)
			burst_left--;
		in_valid <= 1'b1;
		kind <= k;
		key <= ky;
		handle <= h;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	function automatic int find_slot(input bit want_used);
		int start;
		int s;
		start = $urandom_range(0, SLOT_COUNT - 1);
		for (int i = 0; i < SLOT_COUNT; i++) begin
			s = (start + i) % SLOT_COUNT;
			if (used_map[s] == want_used)
				return s;
		end
		return -1;
	endfunction

	// mostly live handles, then stale versions, freed slots, ids past the table
	function automatic logic [HANDLE_W-1:0] pick_handle();
		int r;
		int s;
		logic [HANDLE_W-1:0] h;
		r = $urandom_range(0, 99);
		h = $urandom;
		if (r < 65) begin
			s = find_slot(1'b1);
			if (s >= 0)
				h = live_handle[s];
		end else if (r < 78) begin
			s = find_slot(1'b1);
			if (s >= 0)
				h = {live_handle[s][HANDLE_W-1 -: VER_W] ^ VER_W'($urandom_range(1, 16'hFFFF)),
					live_handle[s][ID_W-1:0]};
		end else if (r < 88) begin
			s = find_slot(1'b0);
			if (s >= 0)
				h = live_handle[s];
		end else if (r < 95) begin
			h[ID_W-1:0] = ID_W'($urandom_range(SLOT_COUNT, 16'hFFFF));
		end
		return h;
	endfunction

	function automatic logic [KEY_W-1:0] pick_key();
		if ($urandom_range(0, 3) != 0)
			return key_pool[$urandom_range(0, 7)];
		return $urandom;
	endfunction

	// weights in percent: allocate, release, lookup handle, lookup key, release all
	task automatic run_phase(input int count, input int w_alloc, input int w_rel,
			input int w_look_h, input int w_look_k, input int w_all);
		int r;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < w_alloc)
				push_item(KIND_ALLOC, pick_key(), $urandom);
			else if (r < w_alloc + w_rel)
				push_item(KIND_RELEASE, $urandom, pick_handle());
			else if (r < w_alloc + w_rel + w_look_h)
				push_item(KIND_LOOKUP_H, $urandom, pick_handle());
			else if (r < w_alloc + w_rel + w_look_h + w_look_k)
				push_item(KIND_LOOKUP_K, pick_key(), $urandom);
			else if (r < w_alloc + w_rel + w_look_h + w_look_k + w_all)
				push_item(KIND_RELEASE_ALL, $urandom, $urandom);
			else
				push_item(KIND_W'($urandom_range(KIND_BAD_LO, KIND_BAD_HI)), $urandom, $urandom);
		end
	endtask

	initial begin
		burst_left = 0;
		key_pool[0] = '0;
		key_pool[1] = '1;
		for (int i = 2; i < 8; i++)
			key_pool[i] = $urandom;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part on an empty table
		push_item(KIND_RELEASE_ALL, '0, '0);
		push_item(KIND_LOOKUP_K, '0, '1);
		push_item(KIND_ALLOC, '0, '0);
		push_item(KIND_ALLOC, '1, '1);
		push_item(KIND_ALLOC, '0, '0);
		push_item(KIND_LOOKUP_K, '0, '0);
		push_item(KIND_LOOKUP_K, '1, '0);
		push_item(KIND_LOOKUP_H, '0, 32'h0001_0001);
		push_item(KIND_LOOKUP_H, '0, 32'h0002_0001);
		push_item(KIND_LOOKUP_H, '0, 32'h0001_FFFF);
		push_item(KIND_LOOKUP_H, '0, 32'h0001_0000 | SLOT_COUNT);
		push_item(KIND_RELEASE, '0, 32'h0001_0000);
		push_item(KIND_RELEASE, '0, 32'h0001_0000);
		push_item(KIND_LOOKUP_K, '0, '0);
		push_item(KIND_ALLOC, 32'h1234_5678, '0);
		push_item(KIND_RELEASE, '0, 32'h0001_0000);
		push_item(KIND_LOOKUP_H, '0, 32'h0001_0000);
		push_item(KIND_RELEASE, '0, 32'hFFFF_0001);
		for (int k = KIND_BAD_LO; k <= KIND_BAD_HI; k++)
			push_item(KIND_W'(k), '1, '1);
		push_item(KIND_RELEASE_ALL, '1, '1);
		push_item(KIND_LOOKUP_H, '0, 32'h0001_0001);
		push_item(KIND_ALLOC, 32'hA5A5_A5A5, '0);

		// random part
		run_phase(70, 60, 10, 12, 12, 2);
		choke_rx <= 1'b1;
		run_phase(60, 35, 20, 18, 20, 3);
		run_phase(70, 15, 45, 15, 15, 5);
		run_phase(80, 30, 25, 15, 20, 5);
		run_phase(70, 60, 10, 12, 12, 2);
		run_phase(80, 30, 25, 15, 20, 5);

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
